@@ rtl/framed_position_parser_fifo_defines.svh @@
// Assertion macros shared by the frame parser RTL.
// Expects signals named clk and arst_n in the scope where a macro is used.
`ifndef FRAMED_POSITION_PARSER_FIFO_DEFINES_SVH
`define FRAMED_POSITION_PARSER_FIFO_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked check that is ignored while reset is asserted.
`define FPP_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("fpp assertion failed");
// Clocked check that also holds during reset.
`define FPP_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("fpp assertion failed");
`else
`define FPP_ASSERT(lbl, prop)
`define FPP_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

@@ rtl/fpp_pkg.sv @@
// Shared constants for the framed position parser with its value queue.
// No dependencies; used by the channel interfaces and the top level.
package fpp_pkg;

	localparam int CMD_W   = 2;
	localparam int BYTE_W  = 8;
	localparam int VALUE_W = 16;
	localparam int LEVEL_W = 3;
	localparam int COUNT_W = 32;

	localparam int QUEUE_DEPTH_DEF = 8;

	localparam logic [CMD_W-1:0] CMD_BYTE  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TAKE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	localparam logic [BYTE_W-1:0] FRAME_HEAD = 8'hAA;
	localparam logic [BYTE_W-1:0] FRAME_TAIL = 8'hBB;

endpackage

@@ rtl/fpp_in_if.sv @@
// Input channel of the frame parser: a command and a received byte.
// Depends on fpp_pkg for field widths.
interface fpp_in_if
	import fpp_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    cmd;
	logic [BYTE_W-1:0]   rx_byte;

	modport source (output valid, cmd, rx_byte, input ready);
	modport sink   (input valid, cmd, rx_byte, output ready);
endinterface

@@ rtl/fpp_out_if.sv @@
// Result channel of the frame parser: per-item flags, popped value and status.
// Depends on fpp_pkg for field widths.
interface fpp_out_if
	import fpp_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic                 frame_done;
	logic                 taken;
	logic [VALUE_W-1:0]   taken_x;
	logic [VALUE_W-1:0]   latest_x;
	logic                 latest_valid;
	logic [LEVEL_W-1:0]   queue_level;
	logic [COUNT_W-1:0]   byte_total;
	logic [COUNT_W-1:0]   frame_total;
	logic [BYTE_W-1:0]    last_rx;

	modport source (output valid, frame_done, taken, taken_x, latest_x, latest_valid,
		queue_level, byte_total, frame_total, last_rx, input ready);
	modport sink   (input valid, frame_done, taken, taken_x, latest_x, latest_valid,
		queue_level, byte_total, frame_total, last_rx, output ready);
endinterface

@@ rtl/fpp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on fpp_pkg for default sizes.
module fpp_ram
	import fpp_pkg::*;
#(
	parameter int WIDTH = VALUE_W,
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                                     clk,
	input  logic                                     wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                         wr_data,
	input  logic                                     rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

@@ rtl/framed_position_parser_fifo.sv @@
// Frame parser for header/low/high/tail position frames with a ring queue.
// Depends on fpp_pkg, fpp_in_if, fpp_out_if, fpp_ram and the assertion header.
//
// Usage:
//   req carries one command per transfer: a received byte, a take of the
//   oldest queued value, or a clear of parser, latest value and queue.
//   rsp returns exactly one status item per request transfer, in order,
//   showing the state after that command (flags, popped value, counters).
// Pipeline: a request accepted on req passes through one stage that holds
//   the status and reads the queue RAM, then the output register, before
//   it is presented on rsp. Throughput is one item per cycle while rsp.ready
//   is high; the queue RAM has one write and one read port, and each
//   command uses at most one of them.
// Stalls: while rsp.ready is low the output register holds its item and
//   the middle stage still takes one more request; req.ready drops only
//   when both are full.
// Reset: arst_n clears the parser, counters, latest value and queue
//   pointers at once; no clearing pass is needed and requests are taken
//   right after reset. Queue RAM contents are not cleared.
`include "framed_position_parser_fifo_defines.svh"

module framed_position_parser_fifo
	import fpp_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	fpp_in_if.sink     req,
	fpp_out_if.source  rsp
);
	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int LW = PW + 1;
	localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_LOW    = 2'd1;
	localparam logic [1:0] PH_HIGH   = 2'd2;
	localparam logic [1:0] PH_TAIL   = 2'd3;

	typedef struct packed {
		logic                frame_done;
		logic                taken;
		logic [VALUE_W-1:0]  latest_x;
		logic                latest_valid;
		logic [LEVEL_W-1:0]  queue_level;
		logic [COUNT_W-1:0]  byte_total;
		logic [COUNT_W-1:0]  frame_total;
		logic [BYTE_W-1:0]   last_rx;
	} stat_t;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		return (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	// Architectural state
	logic [1:0]          phase_q, phase_d;
	logic [BYTE_W-1:0]   low_q, low_d;
	logic [BYTE_W-1:0]   high_q, high_d;
	logic [VALUE_W-1:0]  newest_q, newest_d;
	logic                flag_q, flag_d;
	logic [PW-1:0]       put_q, put_d;
	logic [PW-1:0]       get_q, get_d;
	logic [COUNT_W-1:0]  bytes_q, bytes_d;
	logic [COUNT_W-1:0]  frames_q, frames_d;
	logic [BYTE_W-1:0]   recent_q, recent_d;

	logic                acc;
	logic                done;
	logic                took;
	logic                wr_en;
	logic                rd_en;
	logic [PW-1:0]       put_nxt;
	logic [LW-1:0]       level_d;
	logic [LW-1:0]       level_cur;
	logic [VALUE_W-1:0]  ram_rd_data;

	// Pipeline
	logic                s1_valid;
	stat_t               stat_s1;
	logic                s1_adv;
	logic                out_valid_q;
	stat_t               stat_q;
	logic [VALUE_W-1:0]  taken_x_q;

	assign s1_adv    = s1_valid && (!out_valid_q || rsp.ready);
	assign req.ready = !s1_valid || s1_adv;
	assign acc       = req.valid && req.ready;
	assign put_nxt   = ptr_next(put_q);

	always_comb begin
		phase_d  = phase_q;
		low_d    = low_q;
		high_d   = high_q;
		newest_d = newest_q;
		flag_d   = flag_q;
		put_d    = put_q;
		get_d    = get_q;
		bytes_d  = bytes_q;
		frames_d = frames_q;
		recent_d = recent_q;
		done     = 1'b0;
		took     = 1'b0;
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		if (acc) begin
			unique case (req.cmd)
				CMD_BYTE: begin
					bytes_d  = bytes_q + 1'b1;
					recent_d = req.rx_byte;
					unique case (phase_q)
						PH_HEADER: begin
							if (req.rx_byte == FRAME_HEAD) begin
								phase_d = PH_LOW;
							end
						end
						PH_LOW: begin
							low_d   = req.rx_byte;
							phase_d = PH_HIGH;
						end
						PH_HIGH: begin
							if (req.rx_byte == FRAME_HEAD) begin
								phase_d = PH_LOW;
							end else begin
								high_d  = req.rx_byte;
								phase_d = PH_TAIL;
							end
						end
						PH_TAIL: begin
							priority if (req.rx_byte == FRAME_TAIL) begin
								done     = 1'b1;
								newest_d = {high_q, low_q};
								flag_d   = 1'b1;
								frames_d = frames_q + 1'b1;
								phase_d  = PH_HEADER;
								// A full queue drops the value but still counts the frame.
								if (put_nxt != get_q) begin
									wr_en = 1'b1;
									put_d = put_nxt;
								end
							end else if (req.rx_byte == FRAME_HEAD) begin
								phase_d = PH_LOW;
							end else begin
								phase_d = PH_HEADER;
							end
						end
						default: phase_d = PH_HEADER;
					endcase
				end
				CMD_TAKE: begin
					if (get_q != put_q) begin
						rd_en = 1'b1;
						took  = 1'b1;
						get_d = ptr_next(get_q);
					end
				end
				CMD_CLEAR: begin
					phase_d  = PH_HEADER;
					low_d    = '0;
					high_d   = '0;
					newest_d = '0;
					flag_d   = 1'b0;
					put_d    = '0;
					get_d    = '0;
				end
				default: ;
			endcase
		end
	end

	assign level_d = (put_d >= get_d) ? (LW'(put_d) - LW'(get_d))
		: (LW'(put_d) + LW'(QUEUE_DEPTH) - LW'(get_d));
	assign level_cur = (put_q >= get_q) ? (LW'(put_q) - LW'(get_q))
		: (LW'(put_q) + LW'(QUEUE_DEPTH) - LW'(get_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			low_q    <= '0;
			high_q   <= '0;
			newest_q <= '0;
			flag_q   <= 1'b0;
			put_q    <= '0;
			get_q    <= '0;
			bytes_q  <= '0;
			frames_q <= '0;
			recent_q <= '0;
		end else begin
			phase_q  <= phase_d;
			low_q    <= low_d;
			high_q   <= high_d;
			newest_q <= newest_d;
			flag_q   <= flag_d;
			put_q    <= put_d;
			get_q    <= get_d;
			bytes_q  <= bytes_d;
			frames_q <= frames_d;
			recent_q <= recent_d;
		end
	end

	fpp_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (QUEUE_DEPTH)
	) u_ring (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (put_q),
		.wr_data ({high_q, low_q}),
		.rd_en   (rd_en),
		.rd_addr (get_q),
		.rd_data (ram_rd_data)
	);

	// Stage 1 holds the post-command status; the RAM read lands alongside it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (acc) begin
			s1_valid <= 1'b1;
		end else if (s1_adv) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			stat_s1.frame_done   <= done;
			stat_s1.taken        <= took;
			stat_s1.latest_x     <= newest_d;
			stat_s1.latest_valid <= flag_d;
			stat_s1.queue_level  <= LEVEL_W'(level_d);
			stat_s1.byte_total   <= bytes_d;
			stat_s1.frame_total  <= frames_d;
			stat_s1.last_rx      <= recent_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			stat_q    <= stat_s1;
			taken_x_q <= stat_s1.taken ? ram_rd_data : '0;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.frame_done   = stat_q.frame_done;
	assign rsp.taken        = stat_q.taken;
	assign rsp.taken_x      = taken_x_q;
	assign rsp.latest_x     = stat_q.latest_x;
	assign rsp.latest_valid = stat_q.latest_valid;
	assign rsp.queue_level  = stat_q.queue_level;
	assign rsp.byte_total   = stat_q.byte_total;
	assign rsp.frame_total  = stat_q.frame_total;
	assign rsp.last_rx      = stat_q.last_rx;

	// The queue never holds more than one entry less than its depth.
	`FPP_ASSERT(a_level_bound, (level_cur <= LW'(QUEUE_DEPTH - 1)))
	// A stalled stage-1 item is not lost.
	`FPP_ASSERT(a_s1_hold, (s1_valid && !s1_adv |=> s1_valid))
	// A completed frame always leaves the latest value marked valid.
	`FPP_ASSERT(a_done_valid, (s1_valid && stat_s1.frame_done |-> stat_s1.latest_valid))
	// A take from a non-empty queue moves the read pointer.
	`FPP_ASSERT(a_take_moves, (acc && req.cmd == CMD_TAKE && get_q != put_q
		|=> get_q != $past(get_q)))
	// Nothing is ever read and written in the same cycle.
	`FPP_ASSERT_ALWAYS(a_one_port, (!(wr_en && rd_en)))
endmodule

@@ bench/fpp_status_check.sv @@
// Status checker for the frame parser: predicts one status item per request transfer.
// Depends on fpp_pkg and on the fpp_in_if and fpp_out_if channel interfaces.
// Reports mismatches and hands the failure count and the number of open items to the top.
module fpp_status_check
	import fpp_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	fpp_in_if    req,
	fpp_out_if   rsp,
	output int   fail_count,
	output int   pending
);

	typedef enum logic [1:0] {
		SEEK_HEAD,
		GET_LOW,
		GET_HIGH,
		GET_TAIL
	} parse_phase_e;

	typedef struct packed {
		logic               frame_done;
		logic               taken;
		logic [VALUE_W-1:0] taken_x;
		logic [VALUE_W-1:0] latest_x;
		logic               latest_valid;
		logic [LEVEL_W-1:0] queue_level;
		logic [COUNT_W-1:0] byte_total;
		logic [COUNT_W-1:0] frame_total;
		logic [BYTE_W-1:0]  last_rx;
	} status_t;

	parse_phase_e       phase;
	logic [BYTE_W-1:0]  low_b;
	logic [BYTE_W-1:0]  high_b;
	logic [VALUE_W-1:0] newest;
	logic               newest_ok;
	logic [VALUE_W-1:0] ring [QUEUE_DEPTH];
	int                 put_idx;
	int                 get_idx;
	logic [COUNT_W-1:0] bytes_seen;
	logic [COUNT_W-1:0] frames_seen;
	logic [BYTE_W-1:0]  recent;
	status_t            status_q[$];

	function automatic int ring_step(int p);
		return (p + 1 >= QUEUE_DEPTH) ? 0 : p + 1;
	endfunction

	function automatic void clear_parse();
		phase = SEEK_HEAD;
		low_b = '0;
		high_b = '0;
		newest = '0;
		newest_ok = 1'b0;
		put_idx = 0;
		get_idx = 0;
	endfunction

	// The ring keeps one slot free, so a frame that finds it full is counted but not queued.
	function automatic void store_value(logic [VALUE_W-1:0] v);
		newest = v;
		newest_ok = 1'b1;
		frames_seen = frames_seen + 1'b1;
		if (ring_step(put_idx) != get_idx) begin
			ring[put_idx] = v;
			put_idx = ring_step(put_idx);
		end
	endfunction

	function automatic status_t predict_status(logic [CMD_W-1:0] c, logic [BYTE_W-1:0] b);
		status_t s;
		s = '0;
		case (c)
			CMD_BYTE: begin
				bytes_seen = bytes_seen + 1'b1;
				recent = b;
				case (phase)
					SEEK_HEAD: begin
						if (b == FRAME_HEAD)
							phase = GET_LOW;
					end
					GET_LOW: begin
						low_b = b;
						phase = GET_HIGH;
					end
					GET_HIGH: begin
						if (b == FRAME_HEAD) begin
							phase = GET_LOW;
						end else begin
							high_b = b;
							phase = GET_TAIL;
						end
					end
					default: begin
						if (b == FRAME_TAIL) begin
							store_value({high_b, low_b});
							s.frame_done = 1'b1;
							phase = SEEK_HEAD;
						end else if (b == FRAME_HEAD) begin
							phase = GET_LOW;
						end else begin
							phase = SEEK_HEAD;
						end
					end
				endcase
			end
			CMD_TAKE: begin
				if (get_idx != put_idx) begin
					s.taken = 1'b1;
					s.taken_x = ring[get_idx];
					get_idx = ring_step(get_idx);
				end
			end
			CMD_CLEAR: begin
				clear_parse();
			end
			default: begin
			end
		endcase
		s.latest_x = newest;
		s.latest_valid = newest_ok;
		s.queue_level = LEVEL_W'((put_idx + QUEUE_DEPTH - get_idx) % QUEUE_DEPTH);
		s.byte_total = bytes_seen;
		s.frame_total = frames_seen;
		s.last_rx = recent;
		return s;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		status_t got;
		status_t want;
		if (!arst_n) begin
			clear_parse();
			bytes_seen = '0;
			frames_seen = '0;
			recent = '0;
			status_q.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (req.valid && req.ready)
				status_q.push_back(predict_status(req.cmd, req.rx_byte));
			if (rsp.valid && rsp.ready) begin
				got = '{frame_done: rsp.frame_done, taken: rsp.taken, taken_x: rsp.taken_x,
					latest_x: rsp.latest_x, latest_valid: rsp.latest_valid,
					queue_level: rsp.queue_level, byte_total: rsp.byte_total,
					frame_total: rsp.frame_total, last_rx: rsp.last_rx};
				if (status_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected status transfer: %p", got);
				end else begin
					want = status_q.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("status mismatch (expected/actual):");
							$display("  done %b/%b taken %b/%b taken_x %h/%h latest %h/%h valid %b/%b",
								want.frame_done, got.frame_done, want.taken, got.taken,
								want.taken_x, got.taken_x, want.latest_x, got.latest_x,
								want.latest_valid, got.latest_valid);
							$display("  level %0d/%0d bytes %h/%h frames %h/%h last_rx %h/%h",
								want.queue_level, got.queue_level, want.byte_total,
								got.byte_total, want.frame_total, got.frame_total,
								want.last_rx, got.last_rx);
						end
					end
				end
			end
			pending <= status_q.size();
		end
	end

endmodule

@@ bench/tb_framed_position_parser_fifo.sv @@
// Testbench top for the frame parser: clock, reset, request stimulus and result stalls.
// Depends on fpp_pkg, the channel interfaces, the parser RTL and fpp_status_check.
// Directed frames first, then random well-formed and broken frames, takes and clears.
module tb_framed_position_parser_fifo;
	import fpp_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1300;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   item_count;
	int   calm_left;

	fpp_in_if  req ();
	fpp_out_if rsp ();

	framed_position_parser_fifo i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	fpp_status_check i_status_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAIL framed_position_parser_fifo");
		$finish;
	end

	// Mostly short gaps, a few long ones, and now and then a long stretch with none.
	function automatic int next_gap();
		int r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3)
			calm_left = $urandom_range(40, 120);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_item(input logic [CMD_W-1:0] c, input logic [BYTE_W-1:0] b);
		int gap;
		req.valid <= 1'b1;
		req.cmd <= c;
		req.rx_byte <= b;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		if (c != CMD_UNUSED)
			item_count++;
		gap = next_gap();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		send_item(CMD_BYTE, b);
	endtask

	task automatic send_frame(input logic [BYTE_W-1:0] lo, input logic [BYTE_W-1:0] hi);
		send_byte(FRAME_HEAD);
		send_byte(lo);
		send_byte(hi);
		send_byte(FRAME_TAIL);
	endtask

	// The pending count is registered in the checker; drop valid, then poll it on clock edges until it is zero.
	task automatic drain_results();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	function automatic logic [BYTE_W-1:0] random_low();
		return ($urandom_range(0, 7) == 0) ? FRAME_HEAD : BYTE_W'($urandom);
	endfunction

	initial begin
		int run;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
			rsp.ready <= 1'b1;
			repeat (run) @(posedge clk);
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 3);
			if (run > 0) begin
				rsp.ready <= 1'b0;
				repeat (run) @(posedge clk);
			end
		end
	end

	initial begin
		int pick;
		int take_pct;
		int next_flip;
		int n;
		logic fill_bias;
		logic paused;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.cmd = CMD_BYTE;
		req.rx_byte = '0;
		item_count = 0;
		calm_left = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Take from an empty queue, the unused command, a frame of value zero, a frame
		// whose low byte equals the header, and restarts at the high and tail positions.
		send_item(CMD_TAKE, 8'hFF);
		send_item(CMD_UNUSED, 8'hFF);
		send_frame(8'h00, 8'h00);
		send_frame(FRAME_HEAD, 8'hFF);
		send_byte(FRAME_HEAD);
		send_byte(8'h34);
		send_byte(FRAME_HEAD);
		send_byte(8'h56);
		send_byte(8'h78);
		send_byte(FRAME_TAIL);
		send_byte(FRAME_HEAD);
		send_byte(8'h11);
		send_byte(8'h22);
		send_byte(FRAME_HEAD);
		send_byte(8'h33);
		send_byte(8'h44);
		send_byte(FRAME_TAIL);
		send_item(CMD_TAKE, 8'h00);
		send_item(CMD_CLEAR, 8'h5A);
		send_item(CMD_TAKE, 8'hA5);
		drain_results();

		item_count = 0;
		fill_bias = 1'b1;
		paused = 1'b0;
		next_flip = $urandom_range(80, 200);
		while (item_count < RANDOM_ITEMS) begin
			if (item_count >= next_flip) begin
				fill_bias = !fill_bias;
				next_flip = item_count + $urandom_range(80, 200);
			end
			if (!paused && item_count >= RANDOM_ITEMS / 2) begin
				drain_results();
				paused = 1'b1;
			end
			take_pct = fill_bias ? 10 : 35;
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				send_frame(random_low(), BYTE_W'($urandom));
			end else if (pick < 45 + take_pct) begin
				n = $urandom_range(1, 4);
				repeat (n) send_item(CMD_TAKE, BYTE_W'($urandom));
			end else if (pick < 88) begin
				send_byte(FRAME_HEAD);
				send_byte(random_low());
				case ($urandom_range(0, 3))
					0: begin
						send_byte(FRAME_HEAD);
						send_byte(random_low());
						send_byte(BYTE_W'($urandom));
						send_byte(FRAME_TAIL);
					end
					1: begin
						send_byte(BYTE_W'($urandom));
						send_byte(FRAME_HEAD);
						send_byte(random_low());
						send_byte(BYTE_W'($urandom));
						send_byte(FRAME_TAIL);
					end
					2: begin
						send_byte(BYTE_W'($urandom));
						send_byte(BYTE_W'($urandom));
					end
					default: begin
						send_item(CMD_TAKE, BYTE_W'($urandom));
						send_byte(BYTE_W'($urandom));
						send_byte(FRAME_TAIL);
					end
				endcase
			end else if (pick < 95) begin
				n = $urandom_range(1, 6);
				repeat (n) send_byte(BYTE_W'($urandom));
			end else if (pick < 97) begin
				send_item(CMD_CLEAR, BYTE_W'($urandom));
			end else begin
				send_item(CMD_UNUSED, BYTE_W'($urandom));
			end
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("PASS framed_position_parser_fifo");
		else
			$display("FAIL framed_position_parser_fifo");
		$finish;
	end

endmodule
